### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent check on clk_i and rst_ni.
`define ASSERT_DFLT(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### src/prlc_pkg.sv
package prlc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PER_W     = 31;
  localparam int OP_W      = DATA_W + 1;
  localparam int PROD_W    = 2 * OP_W;
  localparam int ACC_W     = DATA_W + 2;
  localparam int IDX_W     = 4;

  localparam logic signed [DATA_W-1:0] INTEGRAL_MAX = 32'sd65536;
  localparam logic signed [DATA_W-1:0] INTEGRAL_MIN = -32'sd65536;

  localparam logic [IDX_W-1:0] REG_KP       = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_KI       = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_KD       = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_PERIOD   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_OUT_MIN  = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_OUT_MAX  = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_STEP_MIN = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_STEP_MAX = IDX_W'(7);

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd_per_period;
    logic        [PER_W-1:0]  sample_period;
    logic signed [DATA_W-1:0] output_min;
    logic signed [DATA_W-1:0] output_max;
    logic signed [DATA_W-1:0] step_min;
    logic        [PER_W-1:0]  step_max;
  } cfg_t;

  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [DATA_W-1:0] r;
    hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      r = hi[DATA_W-1:0];
    end else if (v < lo) begin
      r = lo[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/prlc_cfg.sv
module prlc_cfg
  import prlc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp            <= '0;
      cfg_q.ki            <= '0;
      cfg_q.kd_per_period <= '0;
      cfg_q.sample_period <= PER_W'(65536);
      cfg_q.output_min    <= -32'sd6554;
      cfg_q.output_max    <= 32'sd6554;
      cfg_q.step_min      <= -32'sd65536;
      cfg_q.step_max      <= PER_W'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KP:       cfg_q.kp            <= cfg_data_i;
        REG_KI:       cfg_q.ki            <= cfg_data_i;
        REG_KD:       cfg_q.kd_per_period <= cfg_data_i;
        REG_PERIOD:   cfg_q.sample_period <= cfg_data_i[PER_W-1:0];
        REG_OUT_MIN:  cfg_q.output_min    <= cfg_data_i;
        REG_OUT_MAX:  cfg_q.output_max    <= cfg_data_i;
        REG_STEP_MIN: cfg_q.step_min      <= cfg_data_i;
        REG_STEP_MAX: cfg_q.step_max      <= cfg_data_i[PER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/prlc_mul.sv
module prlc_mul
  import prlc_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [OP_W-1:0]   op_a_i,
  input  logic signed [OP_W-1:0]   op_b_i,
  output logic signed [DATA_W-1:0] term_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] shifted;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  // drop fraction bits toward minus infinity, then saturate
  assign shifted = prod_q >>> FRAC_BITS;

  always_comb begin
    if (!shifted[PROD_W-1] && (shifted[PROD_W-2:DATA_W-1] != '0)) begin
      term_o = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (shifted[PROD_W-1] && (shifted[PROD_W-2:DATA_W-1] != '1)) begin
      term_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      term_o = shifted[DATA_W-1:0];
    end
  end

endmodule

### src/pid_rate_limited_controller.sv
// PID controller with clamped integral, output clamp and output step limit, signed Q16.16.
// One sample goes in per input transaction (clear_state in tuser) and one drive value comes
// out per output transaction. For a normal sample the sequencer forms the error, runs the
// integral, proportional, derivative and integral-gain products one after another through a
// single registered 33x33 multiplier, then clamps and rate-limits; the final step writes the
// output register. A clear sample goes straight from acceptance to the final step. The input
// is ready only while the sequencer is idle; a finished result may wait in the output register
// while the next sample is worked on, and the final step holds until that register is free.
// Configuration writes are always accepted.
module pid_rate_limited_controller
  import prlc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // measurement[31:0], setpoint[63:32]
  input  logic              s_axis_tuser,   // clear_state[0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // drive[31:0]
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_MI    = 4'd2;
  localparam logic [3:0] S_MP    = 4'd3;
  localparam logic [3:0] S_MD    = 4'd4;
  localparam logic [3:0] S_MK    = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_STEP  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  cfg_t cfg;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire, out_free;

  logic signed [DATA_W-1:0] meas_q, setp_q, err_q, total_q, drive_q;
  logic signed [DATA_W-1:0] integral_q, prior_q, last_q;
  logic signed [OP_W-1:0]   diff_q, change_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [DATA_W-1:0] term;
  logic signed [OP_W-1:0]   isum, ilim;
  logic signed [ACC_W-1:0]  tsum;
  logic signed [OP_W-1:0]   csum;
  logic signed [DATA_W-1:0] drive_new;

  prlc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  prlc_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .term_o (term)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drive_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MI: begin
        mul_a = OP_W'(err_q);
        mul_b = {2'b00, cfg.sample_period};
      end
      S_MP: begin
        mul_a = OP_W'(cfg.kp);
        mul_b = OP_W'(err_q);
      end
      S_MD: begin
        mul_a = OP_W'(cfg.kd_per_period);
        mul_b = diff_q;
      end
      S_MK: begin
        mul_a = OP_W'(cfg.ki);
        mul_b = OP_W'(integral_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    isum = OP_W'(integral_q) + OP_W'(term);
    ilim = isum;
    if (ilim > OP_W'(INTEGRAL_MAX)) ilim = OP_W'(INTEGRAL_MAX);
    if (ilim < OP_W'(INTEGRAL_MIN)) ilim = OP_W'(INTEGRAL_MIN);

    tsum = acc_q;
    if (tsum > ACC_W'(cfg.output_max)) tsum = ACC_W'(cfg.output_max);
    if (tsum < ACC_W'(cfg.output_min)) tsum = ACC_W'(cfg.output_min);

    csum = OP_W'(total_q) - OP_W'(last_q);
    if (csum > $signed({2'b00, cfg.step_max})) csum = $signed({2'b00, cfg.step_max});
    if (csum < OP_W'(cfg.step_min)) csum = OP_W'(cfg.step_min);

    drive_new = sat_acc(ACC_W'(last_q) + ACC_W'(change_q));
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = s_axis_tuser ? S_DONE : S_ERR;
      S_ERR:   state_d = S_MI;
      S_MI:    state_d = S_MP;
      S_MP:    state_d = S_MD;
      S_MD:    state_d = S_MK;
      S_MK:    state_d = S_SUM;
      S_SUM:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_STEP;
      S_STEP:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      integral_q  <= '0;
      prior_q     <= '0;
      last_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire && s_axis_tuser) begin
        integral_q <= '0;
        last_q     <= '0;
      end
      if (state_q == S_MP) begin
        integral_q <= ilim[DATA_W-1:0];
      end
      if ((state_q == S_DONE) && out_free) begin
        last_q  <= drive_new;
        prior_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_q   <= $signed(s_axis_tdata[31:0]);
      setp_q   <= $signed(s_axis_tdata[63:32]);
      err_q    <= '0;
      change_q <= '0;
    end
    unique case (state_q)
      S_ERR:   err_q    <= sat_acc(ACC_W'(setp_q) - ACC_W'(meas_q));
      S_MI:    diff_q   <= OP_W'(err_q) - OP_W'(prior_q);
      S_MD:    acc_q    <= ACC_W'(term);
      S_MK:    acc_q    <= acc_q + ACC_W'(term);
      S_SUM:   acc_q    <= acc_q + ACC_W'(term);
      S_CLAMP: total_q  <= tsum[DATA_W-1:0];
      S_STEP:  change_q <= csum;
      S_DONE:  if (out_free) drive_q <= drive_new;
      default: ;
    endcase
  end

  `ASSERT_DFLT(a_integral_max, integral_q <= INTEGRAL_MAX, "integral above upper limit")
  `ASSERT_DFLT(a_integral_min, integral_q >= INTEGRAL_MIN, "integral below lower limit")
  `ASSERT_DFLT(a_valid_src, $rose(m_axis_tvalid) |-> ($past(state_q) == S_DONE), "early valid")
  `ASSERT_DFLT(a_busy_after_accept, in_fire |=> (state_q != S_IDLE), "idle after transaction")

endmodule
